/* rtl/psg_pkg.sv */
// ---------------------------------------------------------------------------
// psg_pkg
// Shared types and constants of the streaming PPM grayscale filter.
// ---------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

  // header bytes that steer the parser
  localparam logic [7:0] NL_BYTE   = 8'h0A;
  localparam logic [7:0] HASH_BYTE = 8'h23;

  // number of newlines that close the header
  localparam logic [1:0] HEADER_LINES = 2'd3;

  // luma weights 0.299, 0.587, 0.114 as unsigned Q0.16
  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;

  // width of one weighted product and of the weighted sum
  localparam int unsigned PROD_W = 24;

  // number of output items a job expands to
  localparam logic [1:0] ONE_ITEM    = 2'd1;
  localparam logic [1:0] TWO_ITEMS   = 2'd2;
  localparam logic [1:0] THREE_ITEMS = 2'd3;

  // one job handed from the parser to the output side
  typedef struct packed {
    logic [1:0]        count;   // output items to emit, 1..3
    logic              last;    // last item of the job closes the file
    logic              gray;    // emit the luma of the products
    logic [7:0]        byte0;   // first raw byte
    logic [7:0]        byte1;   // second raw byte
    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_g;
    logic [PROD_W-1:0] prod_b;
  } psg_job_t;

  // queue status seen by the parser
  typedef struct packed {
    logic full;
    logic empty;
  } psg_qstat_t;

endpackage

`default_nettype wire

/* rtl/psg_ifs.sv */
// ---------------------------------------------------------------------------
// psg stream interfaces
// Valid/ready channels for PPM input bytes and filtered output bytes.
// ---------------------------------------------------------------------------
`default_nettype none

interface psg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_final;

  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink (input valid, input data_byte, input is_final, output ready);
endinterface

interface psg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

/* rtl/psg_front.sv */
// ---------------------------------------------------------------------------
// psg_front
// Byte parser: tracks header and comment state, groups pixel bytes into
// triples and pushes one job per byte run that produces output.
// ---------------------------------------------------------------------------
`default_nettype none

module psg_front
  import psg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  psg_in_if.sink         feed,
  input  wire psg_qstat_t qstat,
  output logic           push,
  output psg_job_t       job
);

  typedef enum logic [1:0] {
    PHASE_RED   = 2'd0,
    PHASE_GREEN = 2'd1,
    PHASE_BLUE  = 2'd2
  } phase_t;

  logic [1:0] newline_count;
  logic       in_comment;
  phase_t     phase;
  logic [7:0] held_red;
  logic [7:0] held_green;

  logic       accept;
  logic       in_header;
  logic [7:0] b;
  logic       fin;

  assign feed.ready = !qstat.full;
  assign accept     = feed.valid && feed.ready;
  assign in_header  = (newline_count != HEADER_LINES);
  assign b          = feed.data_byte;
  assign fin        = feed.is_final;

  // classify the byte and build the job
  always_comb begin
    job.count  = ONE_ITEM;
    job.last   = fin;
    job.gray   = 1'b0;
    job.byte0  = b;
    job.byte1  = b;
    job.prod_r = {8'd0, W_RED} * {16'd0, held_red};
    job.prod_g = {8'd0, W_GREEN} * {16'd0, held_green};
    job.prod_b = {8'd0, W_BLUE} * {16'd0, b};
    push       = 1'b0;
    if (in_header) begin
      push = accept;
    end else begin
      case (phase)
        PHASE_RED: begin
          // partial triple of one byte at end of file
          push = accept && fin;
        end
        PHASE_GREEN: begin
          // partial triple of two bytes at end of file
          job.count = TWO_ITEMS;
          job.byte0 = held_red;
          push      = accept && fin;
        end
        PHASE_BLUE: begin
          job.count = THREE_ITEMS;
          job.gray  = 1'b1;
          push      = accept;
        end
        default: begin
          push = accept && fin;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      newline_count <= '0;
      in_comment    <= 1'b0;
      phase         <= PHASE_RED;
      held_red      <= '0;
      held_green    <= '0;
    end else if (accept) begin
      if (fin) begin
        newline_count <= '0;
        in_comment    <= 1'b0;
        phase         <= PHASE_RED;
        held_red      <= '0;
        held_green    <= '0;
      end else if (in_header) begin
        if (in_comment) begin
          if (b == NL_BYTE) begin
            in_comment <= 1'b0;
          end
        end else if (b == NL_BYTE) begin
          newline_count <= newline_count + 2'd1;
        end else if (b == HASH_BYTE) begin
          in_comment <= 1'b1;
        end
      end else begin
        case (phase)
          PHASE_RED: begin
            held_red <= b;
            phase    <= PHASE_GREEN;
          end
          PHASE_GREEN: begin
            held_green <= b;
            phase      <= PHASE_BLUE;
          end
          default: begin
            phase <= PHASE_RED;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/psg_queue.sv */
// ---------------------------------------------------------------------------
// psg_queue
// Small job queue between the parser and the output side.
// ---------------------------------------------------------------------------
`default_nettype none

module psg_queue
  import psg_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire psg_job_t   push_job,
  input  wire logic       pop,
  output psg_qstat_t      qstat,
  output psg_job_t        head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  psg_job_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full  = (count == FULL_CNT);
  assign qstat.empty = (count == '0);
  assign head        = slots[rd_ptr];

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("job popped from an empty queue");

  a_job_nonzero: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_job.count != 2'd0))
    else $error("job with no output items");
`endif

endmodule

`default_nettype wire

/* rtl/psg_back.sv */
// ---------------------------------------------------------------------------
// psg_back
// Output side: expands each job into one to three output items, forms the
// luma sum, and holds the result in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module psg_back
  import psg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire psg_qstat_t qstat,
  input  wire psg_job_t   head,
  output logic            pop,
  psg_out_if.source       result
);

  logic [1:0]        emit_idx;
  logic              out_valid;
  logic [7:0]        out_byte;
  logic              out_last;

  logic              load;
  logic              take;
  logic              end_of_job;
  logic [PROD_W-1:0] sum;
  logic [7:0]        next_byte;

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.out_last = out_last;

  // output register is free or being emptied
  assign load       = !out_valid || result.ready;
  assign take       = load && !qstat.empty;
  assign end_of_job = (emit_idx == head.count - 2'd1);
  assign pop        = take && end_of_job;

  // luma: weights sum to 1.0, so the top byte never overflows
  assign sum = head.prod_r + head.prod_g + head.prod_b;

  // pick the byte for the current item of the job
  always_comb begin
    if (head.gray) begin
      next_byte = sum[PROD_W-1 -: 8];
    end else if (emit_idx == 2'd0) begin
      next_byte = head.byte0;
    end else begin
      next_byte = head.byte1;
    end
  end

  // item counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        emit_idx  <= end_of_job ? 2'd0 : emit_idx + 2'd1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= next_byte;
      out_last <= head.last && end_of_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    !qstat.empty |-> (emit_idx < head.count))
    else $error("item index past end of job");

  a_idle_idx_zero: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> (emit_idx == 2'd0))
    else $error("item index left open with no job queued");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
    else $error("output item changed while stalled");
`endif

endmodule

`default_nettype wire

/* rtl/ppm_stream_grayscale_top.sv */
// ---------------------------------------------------------------------------
// ppm_stream_grayscale_top
// Streaming BT.601 grayscale filter for binary P6 PPM files.
// ---------------------------------------------------------------------------
// feed carries the file one byte per item, is_final on its last byte.
// result carries a file of the same length: header bytes unchanged, then
// each R,G,B triple replaced by three copies of its luma; a partial triple
// at the end of the file is flushed unchanged. out_last marks the last item.
// Bytes after an is_final item start a new file.
// A pixel triple drains from one job as three consecutive output items.
// Throughput: one input byte per cycle sustained while result is ready, set
// by the output register emitting one item per cycle; feed.ready drops only
// while the job queue (QUEUE_DEPTH jobs) is full.
// Reset (rst, synchronous) returns the parser to the start of a header and
// empties the queue and output register.
// A stall on result holds the output item; the queue absorbs new jobs until
// full, then feed.ready falls.
// ---------------------------------------------------------------------------
`default_nettype none

module ppm_stream_grayscale_top
  import psg_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  psg_in_if.sink      feed,
  psg_out_if.source   result
);

  psg_qstat_t qstat;
  psg_job_t   push_job;
  psg_job_t   head;
  logic       push;
  logic       pop;

  // parser
  psg_front u_front (
    .clk   (clk),
    .rst   (rst),
    .feed  (feed),
    .qstat (qstat),
    .push  (push),
    .job   (push_job)
  );

  // job queue
  psg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .qstat    (qstat),
    .head     (head)
  );

  // output expansion
  psg_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

/* tb/sv/psg_luma_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// psg_luma_checker
// Watches the feed and result channels of the PPM grayscale filter, tracks
// the header parser and the pixel triples on its own, and compares every
// output item in order with the bytes it predicts.
// ---------------------------------------------------------------------------
module psg_luma_checker
  import psg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  psg_in_if           feed,
  psg_out_if          result,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  // position inside the current pixel triple
  localparam logic [1:0] PH_RED   = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_BLUE  = 2'd2;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } psg_out_beat_t;

  psg_out_beat_t expected_bytes[$];
  psg_out_beat_t want;
  int unsigned   mismatch_total;
  int unsigned   beat_index;

  // own copy of the parser state
  logic [1:0] hdr_lines;
  logic       comment_open;
  logic [1:0] pixel_phase;
  logic [7:0] red_byte;
  logic [7:0] green_byte;

  assign fail_count = mismatch_total;

  function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [31:0] acc;
    acc = 32'(W_RED) * 32'(r) + 32'(W_GREEN) * 32'(g) + 32'(W_BLUE) * 32'(b);
    // weights add up to 1.0, so the sum stays below 2^24
    return acc[23:16];
  endfunction

  task automatic clear_parser();
    hdr_lines    = '0;
    comment_open = 1'b0;
    pixel_phase  = PH_RED;
    red_byte     = '0;
    green_byte   = '0;
  endtask

  task automatic push_beat(input logic [7:0] value, input logic last);
    psg_out_beat_t beat;
    beat.value = value;
    beat.last  = last;
    expected_bytes.push_back(beat);
  endtask

  // expected output items for one accepted input byte
  task automatic predict_ppm_byte(input logic [7:0] b, input logic fin);
    logic [7:0] gray;
    if (hdr_lines < HEADER_LINES) begin
      push_beat(b, fin);
      if (comment_open) begin
        if (b == NL_BYTE) comment_open = 1'b0;
      end else if (b == NL_BYTE) begin
        hdr_lines = hdr_lines + 2'd1;
      end else if (b == HASH_BYTE) begin
        comment_open = 1'b1;
      end
    end else begin
      case (pixel_phase)
        PH_RED: begin
          red_byte    = b;
          pixel_phase = PH_GREEN;
          if (fin) push_beat(red_byte, 1'b1);
        end
        PH_GREEN: begin
          green_byte  = b;
          pixel_phase = PH_BLUE;
          if (fin) begin
            push_beat(red_byte, 1'b0);
            push_beat(green_byte, 1'b1);
          end
        end
        default: begin
          gray = luma_of(red_byte, green_byte, b);
          push_beat(gray, 1'b0);
          push_beat(gray, 1'b0);
          push_beat(gray, fin);
          pixel_phase = PH_RED;
        end
      endcase
    end
    // a final byte closes the file, the next byte starts a new header
    if (fin) clear_parser();
  endtask

  task automatic note_error(input string what, input logic [7:0] exp_value,
                            input logic exp_last);
    mismatch_total++;
    if (mismatch_total <= 10)
      $display("%0t: %s at output item %0d: expected byte %h last %b, got byte %h last %b",
               $realtime, what, beat_index, exp_value, exp_last,
               result.out_byte, result.out_last);
  endtask

  initial begin
    mismatch_total = 0;
    beat_index     = 0;
    outstanding    = 0;
    clear_parser();
  end

  // predict on feed items, compare on result items
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_bytes.delete();
      outstanding <= 0;
    end else begin
      if (feed.valid && feed.ready) predict_ppm_byte(feed.data_byte, feed.is_final);
      if (result.valid && result.ready) begin
        if (expected_bytes.size() == 0) begin
          note_error("unexpected item", 8'h00, 1'b0);
        end else begin
          want = expected_bytes.pop_front();
          if (result.out_byte !== want.value || result.out_last !== want.last)
            note_error("mismatch", want.value, want.last);
        end
        beat_index++;
      end
      outstanding <= expected_bytes.size();
    end
  end

endmodule

/* tb/sv/ppm_stream_grayscale_top_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ppm_stream_grayscale_top_tb
// Feeds the grayscale filter with short PPM files: a directed set of header,
// comment and partial-triple cases, then random files, most well formed and
// some truncated or pure noise. Both channels idle in random bursts; a
// separate checker predicts and compares every output item.
// ---------------------------------------------------------------------------
module ppm_stream_grayscale_top_tb;
  import psg_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned TOTAL_ITEMS  = 475;
  localparam int unsigned CALM_ITEMS   = 60;

  logic clk;
  logic rst;
  bit   idle_on;

  logic [7:0]  ppm_file[$];
  int unsigned items_sent;
  int unsigned quiet_cycles;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned stall_left;

  psg_in_if  feed_if ();
  psg_out_if res_if ();

  ppm_stream_grayscale_top uut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_if),
    .result (res_if)
  );

  psg_luma_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .feed        (feed_if),
    .result      (res_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result side: ready with random stall bursts
  initial begin
    res_if.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!idle_on) begin
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no accepted item, sampled mid-cycle
  always @(negedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((feed_if.valid && feed_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // one feed item, with an optional idle burst ahead of it
  task automatic send_item(input logic [7:0] b, input logic fin);
    bit took;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      feed_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    feed_if.valid     <= 1'b1;
    feed_if.data_byte <= b;
    feed_if.is_final  <= fin;
    // ready is stable in the low half of the cycle
    do begin
      @(negedge clk);
      took = feed_if.ready;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  task automatic send_ppm_file();
    foreach (ppm_file[i]) send_item(ppm_file[i], i == ppm_file.size() - 1);
    ppm_file.delete();
  endtask

  // hold the feed until every predicted item has come out
  task automatic wait_drained();
    feed_if.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == NL_BYTE || b == HASH_BYTE);
    return b;
  endfunction

  // three header lines, some with a comment that may start mid-line
  task automatic add_header();
    logic [7:0] b;
    for (int line = 0; line < 3; line++) begin
      repeat ($urandom_range(0, 4)) ppm_file.push_back(plain_byte());
      if ($urandom_range(0, 3) == 0) begin
        ppm_file.push_back(HASH_BYTE);
        repeat ($urandom_range(0, 5)) begin
          do b = 8'($urandom_range(0, 255)); while (b == NL_BYTE);
          ppm_file.push_back(b);
        end
        ppm_file.push_back(NL_BYTE);
      end
      ppm_file.push_back(NL_BYTE);
    end
  endtask

  task automatic build_random_file();
    int unsigned kind;
    int unsigned npix;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // noise, heavy on newlines
      repeat ($urandom_range(1, 10))
        ppm_file.push_back(($urandom_range(0, 3) == 0) ? NL_BYTE : 8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      // header cut short at a random byte, or left whole
      add_header();
      ppm_file = ppm_file[0:$urandom_range(0, ppm_file.size() - 1)];
    end else begin
      add_header();
      npix = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 15);
      repeat (npix) ppm_file.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // stimulus
  initial begin
    rst               <= 1'b1;
    idle_on           <= 1'b1;
    feed_if.valid     <= 1'b0;
    feed_if.data_byte <= 8'h00;
    feed_if.is_final  <= 1'b0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // comment newline not counted, white, black, hash as a pixel,
    // partial triple of two flushed at the end
    ppm_file = '{NL_BYTE, HASH_BYTE, NL_BYTE, NL_BYTE, NL_BYTE,
                 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                 NL_BYTE, HASH_BYTE, 8'h80, 8'hFF, 8'h00};
    send_ppm_file();
    // file that ends inside a header comment
    ppm_file = '{8'h00, NL_BYTE, HASH_BYTE};
    send_ppm_file();
    // single pixel byte flushed at the end
    ppm_file = '{NL_BYTE, NL_BYTE, NL_BYTE, 8'hFF};
    send_ppm_file();
    wait_drained();

    // random files, calm at the end
    while (items_sent < TOTAL_ITEMS) begin
      idle_on <= (items_sent < TOTAL_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
      build_random_file();
      send_ppm_file();
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/psg_pkg.sv
rtl/psg_ifs.sv
rtl/psg_front.sv
rtl/psg_queue.sv
rtl/psg_back.sv
rtl/ppm_stream_grayscale_top.sv
tb/sv/psg_luma_checker.sv
tb/sv/ppm_stream_grayscale_top_tb.sv
